[hw/rtl/base64url_stream_decoder_top_macros.svh]
// Assertion macros used by the base64url decoder top level.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef BASE64URL_STREAM_DECODER_TOP_MACROS_SVH
`define BASE64URL_STREAM_DECODER_TOP_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define B64D_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/b64d_pkg.sv]
// Package of the base64url decoder: character codes, the sextet lookup and
// the quartet word that travels from the front end to the byte serializer.
`timescale 1ns / 1ps

package b64d_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_UNDER   = 8'h5F;
    localparam logic [7:0] CHAR_EQUALS  = 8'h3D;

    localparam logic [7:0] LOWER_BASE   = 8'd26;
    localparam logic [7:0] DIGIT_BASE   = 8'd52;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    // Byte keep mask of an invalid marker: only the upper byte, which is zero.
    localparam logic [2:0] KEEP_MARKER  = 3'b100;

    // Position of the next character inside its quartet.
    typedef enum logic [3:0] {
        PLACE_FIRST  = 4'b0001,
        PLACE_SECOND = 4'b0010,
        PLACE_THIRD  = 4'b0100,
        PLACE_FOURTH = 4'b1000
    } t_place;

    typedef struct packed {
        logic       is_pad;
        logic       is_bad;
        logic [5:0] value;
    } t_sextet;

    // One queued quartet: three candidate bytes, which of them go out, and flags.
    typedef struct packed {
        logic [23:0] triple;
        logic [2:0]  keep;
        logic        last;
        logic        invalid;
    } t_quartet;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic t_sextet sextet_of(input logic [7:0] ch);
        t_sextet s;
        s.is_pad = 1'b0;
        s.is_bad = 1'b0;
        s.value  = 6'd0;
        if (ch inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
            s.value = 6'(ch - CHAR_UPPER_A);
        end else if (ch inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
            s.value = 6'(ch - CHAR_LOWER_A + LOWER_BASE);
        end else if (ch inside {[CHAR_ZERO:CHAR_NINE]}) begin
            s.value = 6'(ch - CHAR_ZERO + DIGIT_BASE);
        end else if (ch == CHAR_PLUS || ch == CHAR_MINUS) begin
            s.value = SEXTET_PLUS;
        end else if (ch == CHAR_SLASH || ch == CHAR_UNDER) begin
            s.value = SEXTET_SLASH;
        end else if (ch == CHAR_EQUALS) begin
            s.is_pad = 1'b1;
        end else begin
            s.is_bad = 1'b1;
        end
        return s;
    endfunction

endpackage

[hw/rtl/b64d_char_if.sv]
// Input channel of the base64url decoder: one text character per word.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_string;

    modport source (output valid, output char_code, output end_of_string, input ready);
    modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

[hw/rtl/b64d_byte_if.sv]
// Output channel of the base64url decoder: one decoded byte per word.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

interface b64d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_of_string;
    logic       invalid;

    modport source (output valid, output data_byte, output last_of_string, output invalid,
                    input ready);
    modport sink   (input valid, input data_byte, input last_of_string, input invalid,
                    output ready);
endinterface

[hw/rtl/b64d_front.sv]
// Front end: classifies each character, tracks the quartet and queues quartet words.
// Depends on b64d_pkg and b64d_char_if.
`timescale 1ns / 1ps

module b64d_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    b64d_char_if.sink             i_char,
    input  b64d_pkg::t_queue_status i_status,
    output logic                  o_push,
    output b64d_pkg::t_quartet    o_entry
);

    logic [17:0]          r_held, n_held;
    b64d_pkg::t_place     r_place, n_place;
    logic                 r_third_pad, n_third_pad;
    logic                 r_error, n_error;
    b64d_pkg::t_sextet    w_sextet;
    logic                 w_accept;
    logic                 w_emit;
    logic                 w_d_pad;

    assign i_char.ready = !i_status.full;
    assign w_accept     = i_char.valid && i_char.ready;
    assign w_sextet     = b64d_pkg::sextet_of(i_char.char_code);

    always_comb begin
        n_held      = r_held;
        n_place     = r_place;
        n_third_pad = r_third_pad;
        n_error     = r_error;
        w_emit      = 1'b0;
        w_d_pad     = 1'b1;

        if (!r_error) begin
            case (r_place)
                b64d_pkg::PLACE_FIRST: begin
                    if (w_sextet.is_bad || w_sextet.is_pad) begin
                        n_error = 1'b1;
                    end else begin
                        n_held      = {w_sextet.value, 12'd0};
                        n_third_pad = 1'b0;
                        n_place     = b64d_pkg::PLACE_SECOND;
                    end
                end
                b64d_pkg::PLACE_SECOND: begin
                    if (w_sextet.is_bad || w_sextet.is_pad) begin
                        n_error = 1'b1;
                    end else begin
                        n_held[11:6] = w_sextet.value;
                        n_place      = b64d_pkg::PLACE_THIRD;
                    end
                end
                b64d_pkg::PLACE_THIRD: begin
                    if (w_sextet.is_bad) begin
                        n_error = 1'b1;
                    end else begin
                        n_third_pad = w_sextet.is_pad;
                        if (!w_sextet.is_pad) begin
                            n_held[5:0] = w_sextet.value;
                        end
                        n_place = b64d_pkg::PLACE_FOURTH;
                    end
                end
                b64d_pkg::PLACE_FOURTH: begin
                    if (w_sextet.is_bad) begin
                        n_error = 1'b1;
                    end else begin
                        w_emit  = 1'b1;
                        w_d_pad = w_sextet.is_pad;
                        n_place = b64d_pkg::PLACE_FIRST;
                    end
                end
                default: begin
                    n_error = 1'b1;
                end
            endcase
        end

        // Ending mid-quartet: two or three chars are padded out, one is an error.
        if (i_char.end_of_string && !n_error) begin
            if (n_place == b64d_pkg::PLACE_SECOND) begin
                n_error = 1'b1;
            end else if (n_place == b64d_pkg::PLACE_THIRD) begin
                n_third_pad = 1'b1;
                w_emit      = 1'b1;
                w_d_pad     = 1'b1;
            end else if (n_place == b64d_pkg::PLACE_FOURTH) begin
                w_emit  = 1'b1;
                w_d_pad = 1'b1;
            end
        end

        o_entry.triple  = {n_held, (w_d_pad ? 6'd0 : w_sextet.value)};
        o_entry.keep    = {1'b1, !n_third_pad, !w_d_pad};
        o_entry.last    = i_char.end_of_string;
        o_entry.invalid = 1'b0;
        if (i_char.end_of_string && n_error) begin
            o_entry.triple  = 24'd0;
            o_entry.keep    = b64d_pkg::KEEP_MARKER;
            o_entry.invalid = 1'b1;
        end

        o_push = w_accept && (w_emit || i_char.end_of_string);

        if (i_char.end_of_string) begin
            n_held      = 18'd0;
            n_place     = b64d_pkg::PLACE_FIRST;
            n_third_pad = 1'b0;
            n_error     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= 18'd0;
            r_place     <= b64d_pkg::PLACE_FIRST;
            r_third_pad <= 1'b0;
            r_error     <= 1'b0;
        end else if (w_accept) begin
            r_held      <= n_held;
            r_place     <= n_place;
            r_third_pad <= n_third_pad;
            r_error     <= n_error;
        end
    end

endmodule

[hw/rtl/b64d_queue.sv]
// Short queue of quartet words between the front end and the serializer.
// Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_queue #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  b64d_pkg::t_quartet      i_entry,
    input  logic                    i_pop,
    output b64d_pkg::t_quartet      o_head,
    output b64d_pkg::t_queue_status o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64d_pkg::t_quartet r_mem [DEPTH];
    logic [AW-1:0]      r_wr_ptr;
    logic [AW-1:0]      r_rd_ptr;
    logic [CW-1:0]      r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

[hw/rtl/b64d_back.sv]
// Serializer: sends the kept bytes of the head quartet, one per word, from an
// output register. Depends on b64d_pkg and b64d_byte_if.
`timescale 1ns / 1ps

module b64d_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  b64d_pkg::t_quartet      i_head,
    input  b64d_pkg::t_queue_status i_status,
    output logic                    o_pop,
    b64d_byte_if.source             o_byte
);

    logic [2:0] r_done;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_invalid;
    logic [2:0] w_remaining;
    logic [2:0] w_pick;
    logic [7:0] w_byte;
    logic       w_final;
    logic       w_load;

    assign w_remaining = i_head.keep & ~r_done;

    // The highest remaining byte goes first, matching stream order.
    always_comb begin
        if (w_remaining[2]) begin
            w_pick = 3'b100;
            w_byte = i_head.triple[23:16];
        end else if (w_remaining[1]) begin
            w_pick = 3'b010;
            w_byte = i_head.triple[15:8];
        end else begin
            w_pick = 3'b001;
            w_byte = i_head.triple[7:0];
        end
    end

    assign w_final = ((w_remaining & ~w_pick) == 3'b000);
    assign w_load  = !i_status.empty && (!r_valid || o_byte.ready);
    assign o_pop   = w_load && w_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= 3'b000;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_done  <= w_final ? 3'b000 : (r_done | w_pick);
            end else if (o_byte.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte    <= w_byte;
            r_last    <= i_head.last && w_final;
            r_invalid <= i_head.invalid;
        end
    end

    assign o_byte.valid          = r_valid;
    assign o_byte.data_byte      = r_byte;
    assign o_byte.last_of_string = r_last;
    assign o_byte.invalid        = r_invalid;

endmodule

[hw/rtl/base64url_stream_decoder_top.sv]
// Channel   | Direction | Word contents
// ----------+-----------+-------------------------------------------------
// i_char    | in        | char_code[7:0], end_of_string
// o_byte    | out       | data_byte[7:0], last_of_string, invalid
//
// A character word is taken in every cycle while the quartet queue has room.
// Decoded bytes leave one per cycle from an output register while o_byte is ready;
// a quartet's first byte becomes valid once its word is queued and then loaded
// into the output register. A quartet word holds the serializer for one to three
// bytes, so QUEUE_DEPTH sets how long the input side keeps going while o_byte stalls.
// Reset is synchronous and active low; it empties the queue and clears the
// quartet tracking, with no further start-up sweep.
`timescale 1ns / 1ps
`include "base64url_stream_decoder_top_macros.svh"

// Top level of the base64url stream decoder. Depends on b64d_pkg, both channel
// interfaces, b64d_front, b64d_queue and b64d_back.
module base64url_stream_decoder_top #(
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    b64d_char_if.sink  i_char,
    b64d_byte_if.source o_byte
);

    // Quartet words flow from the front end into the queue; the serializer
    // drains the head word byte by byte.
    logic                    w_push;
    logic                    w_pop;
    b64d_pkg::t_quartet      w_entry;
    b64d_pkg::t_quartet      w_head;
    b64d_pkg::t_queue_status w_status;

    // The front end classifies every character, keeps the partial quartet and
    // turns a complete quartet, or the end of a string, into one queue word.
    b64d_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (i_char),
        .i_status (w_status),
        .o_push   (w_push),
        .o_entry  (w_entry)
    );

    // The queue lets character intake continue while bytes wait downstream.
    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_entry),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_status)
    );

    // The serializer emits each kept byte of the head word and pops it as the
    // final one is loaded into the output register.
    b64d_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_status (w_status),
        .o_pop    (w_pop),
        .o_byte   (o_byte)
    );

    // An invalid marker always closes its string and carries a zero byte.
    `B64D_ASSERT(a_marker_last,
        (o_byte.valid && o_byte.invalid) |-> o_byte.last_of_string,
        "invalid word without last flag")
    `B64D_ASSERT(a_marker_zero,
        (o_byte.valid && o_byte.invalid) |-> (o_byte.data_byte == 8'h00),
        "invalid word with nonzero byte")
    // The front end never writes into a full queue, the serializer never pops an empty one.
    `B64D_ASSERT(a_no_overflow,
        (w_push |-> !w_status.full) and (w_pop |-> !w_status.empty),
        "queue overflow or underflow")
    // A waiting quartet reaches the output register as soon as it is free.
    `B64D_ASSERT_NEXT(a_drain,
        !w_status.empty && !(o_byte.valid && !o_byte.ready), o_byte.valid,
        "serializer idle with queued word")

endmodule
